@@ sv/bafs_pkg.sv @@
// Package for the burst assembler: word types, command and result codes, FSM states.
// No dependencies.
package bafs_pkg;
	localparam logic [23:0] MAX24 = 24'hFFFFFF;
	localparam logic [6:0] MAX7 = 7'd127;

	typedef enum logic [1:0] {
		CMD_PACKET = 2'd0,
		CMD_TICK = 2'd1,
		CMD_GRANT = 2'd2,
		CMD_NONE = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		KIND_NOTHING = 3'd0,
		KIND_REQUEST = 3'd1,
		KIND_FAST = 3'd2,
		KIND_SLOW = 3'd3,
		KIND_DROP = 3'd4
	} kind_t;

	localparam logic [2:0] REG_TIMEOUT = 3'd0;
	localparam logic [2:0] REG_MAX_BYTES = 3'd1;
	localparam logic [2:0] REG_MAX_PACKETS = 3'd2;
	localparam logic [2:0] REG_FIXED_HDR = 3'd3;
	localparam logic [2:0] REG_PKT_HDR = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FAST_RD,
		ST_FAST_CHK,
		ST_SLOW_RD,
		ST_SLOW_CHK,
		ST_ARM,
		ST_SUM_RD,
		ST_SUM
	} state_t;

	typedef struct packed {
		logic [1:0] command;
		logic [15:0] packet_bytes;
		logic fast_valid;
		logic slow_valid;
		logic [23:0] fast_limit_bytes;
		logic [23:0] slow_limit_bytes;
	} in_word_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [23:0] size_bytes;
		logic [6:0] packets_in_burst;
		logic [31:0] sequence_res;
		logic last;
	} out_word_t;

	function automatic logic [23:0] add_sat24(input logic [23:0] a, input logic [16:0] b);
		logic [24:0] s;
		s = {1'b0, a} + {8'd0, b};
		return s[24] ? MAX24 : s[23:0];
	endfunction
endpackage

@@ sv/burst_assembler_fast_slow_split.sv @@
// Top level of the hybrid timer-and-size burst assembler with fast/slow split.
// Depends on bafs_pkg and bafs_ram (packet length and arrival tick FIFOs).
// Arrival and tick give their result in the cycle after start and keep busy low,
// so they can be accepted every cycle. A grant at a non-empty queue holds busy
// while it reads and checks each drained packet, closes each burst, re-arms the
// timer and reads and sums each remaining packet for the recount, one step at a
// time, as the FIFO memories have a single read port. The receiver cannot stall.
// Reset clears all control state at once; FIFO contents stay undefined.
module burst_assembler_fast_slow_split
	import bafs_pkg::*;
#(
	parameter int QUEUE_DEPTH = 64
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input in_word_t in_word,
	output logic out_strobe,
	output out_word_t out_word,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [2:0] cfg_index,
	input logic [31:0] cfg_data
);
	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

	logic [31:0] timeout_q;
	logic [23:0] max_bytes_q;
	logic [6:0] max_pk_q;
	logic [7:0] fix_hdr_q, pkt_hdr_q;

	logic [AW-1:0] head_q, tail_q, idx_q;
	logic [CW-1:0] count_q, left_q;
	logic [6:0] pend_pk_q;
	logic [23:0] pend_b_q;
	logic [31:0] tick_q, dead_q, seq_q;
	logic armed_q;
	state_t state_q, state_d;
	in_word_t cmd_q;
	logic [23:0] acc_q;
	logic [CW-1:0] n_q;

	logic we;
	logic [AW-1:0] raddr;
	logic [15:0] len_rd;
	logic [31:0] arr_rd;

	bafs_ram #(.WIDTH(16), .DEPTH(QUEUE_DEPTH)) u_len (
		.clk(clk), .we(we), .waddr(tail_q), .wdata(in_word.packet_bytes),
		.raddr(raddr), .rdata(len_rd)
	);
	bafs_ram #(.WIDTH(32), .DEPTH(QUEUE_DEPTH)) u_arr (
		.clk(clk), .we(we), .waddr(tail_q), .wdata(tick_q),
		.raddr(raddr), .rdata(arr_rd)
	);

	logic acc_in;
	assign acc_in = start && !busy;
	assign busy = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign we = acc_in && (in_word.command == CMD_PACKET) && (count_q < DEPTH_C);
	assign raddr = (state_q == ST_SUM_RD || state_q == ST_SUM) ? idx_q : head_q;

	logic [31:0] eff_to;
	assign eff_to = (timeout_q == 32'd0) ? 32'd1 : timeout_q;

	logic [24:0] fit_sum;
	logic [23:0] cur_lim;
	assign cur_lim = (state_q == ST_FAST_CHK) ? cmd_q.fast_limit_bytes
		: cmd_q.slow_limit_bytes;
	assign fit_sum = {1'b0, acc_q} + {9'd0, len_rd};

	logic chk_done;
	assign chk_done = (count_q == '0) || (fit_sum > {1'b0, cur_lim});

	logic [6:0] n_sat;
	assign n_sat = (n_q > CW'(MAX7)) ? MAX7 : 7'(n_q);
	logic [6:0] cnt_sat;
	assign cnt_sat = (count_q > CW'(MAX7)) ? MAX7 : 7'(count_q);

	logic strobe_d;
	assign strobe_d = (state_q == ST_IDLE && acc_in
			&& !(in_word.command == CMD_GRANT && count_q != '0))
		|| ((state_q == ST_FAST_CHK || state_q == ST_SLOW_CHK) && chk_done)
		|| (state_q == ST_ARM && !cmd_q.fast_valid && !cmd_q.slow_valid);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (acc_in && in_word.command == CMD_GRANT && count_q != '0) begin
					if (in_word.fast_valid) begin
						state_d = ST_FAST_RD;
					end else if (in_word.slow_valid) begin
						state_d = ST_SLOW_RD;
					end else begin
						state_d = ST_ARM;
					end
				end
			end
			ST_FAST_RD: state_d = ST_FAST_CHK;
			ST_FAST_CHK: begin
				if (chk_done) begin
					state_d = cmd_q.slow_valid ? ST_SLOW_RD : ST_ARM;
				end else begin
					state_d = ST_FAST_RD;
				end
			end
			ST_SLOW_RD: state_d = ST_SLOW_CHK;
			ST_SLOW_CHK: begin
				if (chk_done) begin
					state_d = ST_ARM;
				end else begin
					state_d = ST_SLOW_RD;
				end
			end
			ST_ARM: state_d = (count_q == '0) ? ST_IDLE : ST_SUM_RD;
			ST_SUM_RD: state_d = ST_SUM;
			ST_SUM: state_d = (left_q == CW'(1)) ? ST_IDLE : ST_SUM_RD;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= 32'd1000;
			max_bytes_q <= 24'd9000;
			max_pk_q <= 7'd64;
			fix_hdr_q <= '0;
			pkt_hdr_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_TIMEOUT: timeout_q <= cfg_data;
				REG_MAX_BYTES: max_bytes_q <= cfg_data[23:0];
				REG_MAX_PACKETS: max_pk_q <= cfg_data[6:0];
				REG_FIXED_HDR: fix_hdr_q <= cfg_data[7:0];
				REG_PKT_HDR: pkt_hdr_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	logic [23:0] pb_base, pb_new;
	logic [6:0] pp_new;
	logic [31:0] tick_n, elapsed;
	logic req_hit;
	assign pb_base = (count_q == '0) ? {16'd0, fix_hdr_q} : pend_b_q;
	assign pb_new = add_sat24(pb_base, {1'b0, in_word.packet_bytes} + {9'd0, pkt_hdr_q});
	assign pp_new = (count_q == '0) ? 7'd1 : ((pend_pk_q < MAX7) ? pend_pk_q + 7'd1 : MAX7);
	assign req_hit = (pp_new == max_pk_q) || (pb_new >= max_bytes_q);
	assign tick_n = tick_q + 32'd1;
	assign elapsed = tick_q - arr_rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0; tail_q <= '0; idx_q <= '0;
			count_q <= '0; left_q <= '0;
			pend_pk_q <= '0; pend_b_q <= '0;
			tick_q <= '0; dead_q <= '0; seq_q <= '0;
			armed_q <= 1'b0; out_strobe <= 1'b0;
			acc_q <= '0; n_q <= '0;
			cmd_q <= '0; out_word <= '0;
		end else begin
			out_strobe <= strobe_d;
			case (state_q)
				ST_IDLE: begin
					if (acc_in) begin
						cmd_q <= in_word;
						acc_q <= '0;
						n_q <= '0;
						case (in_word.command)
							CMD_PACKET: begin
								if (count_q >= DEPTH_C) begin
									out_word <= '{KIND_DROP, {8'd0, in_word.packet_bytes},
										7'd0, 32'd0, 1'b1};
								end else begin
									if (count_q == '0) begin
										dead_q <= tick_q + eff_to;
									end
									tail_q <= (tail_q == AW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
									count_q <= count_q + 1'b1;
									if (req_hit) begin
										out_word <= '{KIND_REQUEST, pb_new, pp_new, seq_q, 1'b1};
										pend_pk_q <= '0;
										pend_b_q <= {16'd0, fix_hdr_q};
										armed_q <= 1'b0;
									end else begin
										out_word <= '{KIND_NOTHING, 24'd0, 7'd0, 32'd0, 1'b1};
										pend_pk_q <= pp_new;
										pend_b_q <= pb_new;
										armed_q <= (count_q == '0) ? 1'b1 : armed_q;
									end
								end
							end
							CMD_TICK: begin
								tick_q <= tick_n;
								if (armed_q && tick_n == dead_q) begin
									armed_q <= 1'b0;
								end
								if (armed_q && tick_n == dead_q && count_q != '0) begin
									out_word <= '{KIND_REQUEST, pend_b_q, pend_pk_q, seq_q, 1'b1};
									pend_pk_q <= '0;
									pend_b_q <= {16'd0, fix_hdr_q};
								end else begin
									out_word <= '{KIND_NOTHING, 24'd0, 7'd0, 32'd0, 1'b1};
								end
							end
							CMD_GRANT: begin
								out_word <= '{KIND_NOTHING, 24'd0, 7'd0, 32'd0, 1'b1};
								if (count_q == '0) begin
									armed_q <= 1'b0;
								end
							end
							default: out_word <= '{KIND_NOTHING, 24'd0, 7'd0, 32'd0, 1'b1};
						endcase
					end
				end
				ST_FAST_CHK, ST_SLOW_CHK: begin
					if (chk_done) begin
						out_word <= '{(state_q == ST_FAST_CHK) ? KIND_FAST : KIND_SLOW,
							acc_q, n_sat, seq_q,
							(state_q == ST_SLOW_CHK) || !cmd_q.slow_valid};
						seq_q <= seq_q + 32'd1;
						acc_q <= '0;
						n_q <= '0;
					end else begin
						acc_q <= fit_sum[23:0];
						n_q <= n_q + 1'b1;
						head_q <= (head_q == AW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
						count_q <= count_q - 1'b1;
					end
				end
				ST_ARM: begin
					if (!cmd_q.fast_valid && !cmd_q.slow_valid) begin
						out_word <= '{KIND_NOTHING, 24'd0, 7'd0, 32'd0, 1'b1};
					end
					pend_b_q <= {16'd0, fix_hdr_q};
					pend_pk_q <= cnt_sat;
					if (count_q == '0) begin
						armed_q <= 1'b0;
					end else begin
						armed_q <= 1'b1;
						dead_q <= (elapsed >= eff_to) ? tick_n : arr_rd + eff_to;
						idx_q <= head_q;
						left_q <= count_q;
					end
				end
				ST_SUM: begin
					pend_b_q <= add_sat24(pend_b_q, {1'b0, len_rd} + {9'd0, pkt_hdr_q});
					idx_q <= (idx_q == AW'(QUEUE_DEPTH - 1)) ? '0 : idx_q + 1'b1;
					left_q <= left_q - 1'b1;
				end
				default: ;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C) else $error("queue count exceeds depth");
	a_no_drop_space: assert property (@(posedge clk) disable iff (!arst_n)
		out_strobe && out_word.kind == KIND_DROP |-> count_q == DEPTH_C)
		else $error("drop with free space");
	a_idle_after_strobe_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_strobe && !out_word.last |-> busy) else $error("non-last result while idle");
endmodule

@@ sv/bafs_ram.sv @@
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module bafs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
